// ===== rtl/ppfc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppfc_pkg
// Shared constants and types for the palette pixel format converter.
// ----------------------------------------------------------------------------
package ppfc_pkg;

  localparam int PALETTE_ENTRIES = 16;
  localparam int PAL_IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int IDX_W = 4;
  localparam int SEL_W = (PAL_IDX_W > IDX_W) ? PAL_IDX_W : IDX_W;

  localparam int GUN_W = 8;
  localparam int MAX_W = 16;
  localparam int PROD_W = GUN_W + MAX_W;

  localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(127);
  localparam int GUN_FULL = 255;

  // reciprocal of full scale, exact for every product + bias below 2^24
  localparam int RECIP_K = 32;
  localparam logic [24:0] GUN_RECIP =
    25'(((64'd1 << RECIP_K) + 64'(GUN_FULL - 1)) / 64'(GUN_FULL));

  typedef enum logic [7:0] {
    CFG_BPP        = 8'd0,
    CFG_BIG_ENDIAN = 8'd1,
    CFG_TRUE_COL   = 8'd2,
    CFG_TWO_COL    = 8'd3,
    CFG_RED_MAX    = 8'd4,
    CFG_GREEN_MAX  = 8'd5,
    CFG_BLUE_MAX   = 8'd6,
    CFG_SHIFTS     = 8'd7
  } cfg_reg_e;

  typedef enum logic {
    ACT_WRITE   = 1'b0,
    ACT_CONVERT = 1'b1
  } action_e;

  typedef struct packed {
    logic mul;
    logic div;
  } stage_en_t;

endpackage

// ===== rtl/palette_pixel_format_converter.sv =====
// ----------------------------------------------------------------------------
// palette_pixel_format_converter
// Color index to remote-framebuffer wire pixel, with a loadable palette.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              content
//  s_*       in   s_tvalid / s_tready    palette write or index convert
//  m_*       out  m_tvalid / m_tready    wire bytes and byte count
//  cfg_*     in   cfg_valid / cfg_ready  register index and data
//
//  One word per cycle in while s_tready is high; converts run every stage to m_tvalid.
//  Stages: palette read, gun multiply, reciprocal divide, shift/merge, byte order.
//  Palette writes take effect at accept and produce no output word.
//  Each stage holds on its own when the next is full; bubbles are squeezed out.
//  rst clears control and the palette and loads the config defaults.
// ----------------------------------------------------------------------------
module palette_pixel_format_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // colour_index[3:0], red_in, green_in, blue_in, pad
  input  logic [0:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // pixel_bytes[31:0], byte_count[2:0], pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int N = ppfc_pkg::PALETTE_ENTRIES;
  localparam int GW = ppfc_pkg::GUN_W;
  localparam int MW = ppfc_pkg::MAX_W;

  // config
  logic [7:0]  bpp;
  logic        msb_first;
  logic        rgb_mode;
  logic        two_colour;
  logic [MW-1:0] red_max, grn_max, blu_max;
  logic [23:0] gun_shifts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp         <= 8'd32;
      msb_first   <= 1'b0;
      rgb_mode    <= 1'b1;
      two_colour  <= 1'b0;
      red_max     <= MW'(255);
      grn_max     <= MW'(255);
      blu_max     <= MW'(255);
      gun_shifts  <= 24'h100800;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ppfc_pkg::CFG_BPP:        bpp         <= cfg_data[7:0];
        ppfc_pkg::CFG_BIG_ENDIAN: msb_first   <= cfg_data[0];
        ppfc_pkg::CFG_TRUE_COL:   rgb_mode    <= cfg_data[0];
        ppfc_pkg::CFG_TWO_COL:    two_colour  <= cfg_data[0];
        ppfc_pkg::CFG_RED_MAX:    red_max     <= cfg_data[MW-1:0];
        ppfc_pkg::CFG_GREEN_MAX:  grn_max     <= cfg_data[MW-1:0];
        ppfc_pkg::CFG_BLUE_MAX:   blu_max     <= cfg_data[MW-1:0];
        ppfc_pkg::CFG_SHIFTS:     gun_shifts  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input unpack
  logic [ppfc_pkg::IDX_W-1:0] in_idx;
  logic [GW-1:0] in_red, in_green, in_blue;
  logic [ppfc_pkg::SEL_W-1:0] in_sel;
  logic in_hit;
  logic in_accept;
  logic is_convert;

  assign in_idx   = s_tdata[3:0];
  assign in_red   = s_tdata[11:4];
  assign in_green = s_tdata[19:12];
  assign in_blue  = s_tdata[27:20];
  assign in_sel   = ppfc_pkg::SEL_W'(in_idx);
  assign in_hit   = {1'b0, in_sel} < (ppfc_pkg::SEL_W + 1)'(N);
  assign in_accept  = s_tvalid && s_tready;
  assign is_convert = (s_tuser[0] == ppfc_pkg::ACT_CONVERT);

  // stage ready chain
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !m_tvalid || m_tready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_tready = rdy1;

  // palette
  logic [3*GW-1:0] palette [N];
  logic [3*GW-1:0] rd_entry;

  assign rd_entry = in_hit ? palette[in_sel[ppfc_pkg::PAL_IDX_W-1:0]] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        palette[i] <= '0;
      end
    end else if (in_accept && !is_convert && in_hit) begin
      palette[in_sel[ppfc_pkg::PAL_IDX_W-1:0]] <= {in_red, in_green, in_blue};
    end
  end

  // stage 1: palette read
  logic [ppfc_pkg::IDX_W-1:0] idx1, idx2, idx3;
  logic [3*GW-1:0] entry1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid && is_convert;
    end
    if (rdy1) begin
      idx1   <= in_idx;
      entry1 <= rd_entry;
    end
  end

  // stages 2, 3: scaling
  ppfc_pkg::stage_en_t scale_en;
  logic [MW-1:0] red_q, green_q, blue_q;

  assign scale_en.mul = rdy2;
  assign scale_en.div = rdy3;

  ppfc_gun_scale u_scale_red (
    .clk     (clk),
    .en      (scale_en),
    .gun     (entry1[3*GW-1:2*GW]),
    .gun_max (red_max),
    .scaled  (red_q)
  );

  ppfc_gun_scale u_scale_green (
    .clk     (clk),
    .en      (scale_en),
    .gun     (entry1[2*GW-1:GW]),
    .gun_max (grn_max),
    .scaled  (green_q)
  );

  ppfc_gun_scale u_scale_blue (
    .clk     (clk),
    .en      (scale_en),
    .gun     (entry1[GW-1:0]),
    .gun_max (blu_max),
    .scaled  (blue_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
    if (rdy2) idx2 <= idx1;
    if (rdy3) idx3 <= idx2;
  end

  // stage 4: shift and merge
  function automatic logic [31:0] place_gun(input logic [MW-1:0] val,
                                            input logic [7:0] sh,
                                            input logic [7:0] width);
    logic [31:0] res;
    res = '0;
    if (sh < width && sh < 8'd32) begin
      res = 32'(val) << sh[4:0];
    end
    return res;
  endfunction

  logic [MW-1:0] red_v, green_v, blue_v;
  logic [31:0] pix_next, pix4;

  always_comb begin
    red_v   = two_colour ? red_max : red_q;
    green_v = two_colour ? grn_max : green_q;
    blue_v  = two_colour ? blu_max : blue_q;
    if (!rgb_mode) begin
      pix_next = 32'(idx3);
    end else if (two_colour && idx3 == '0) begin
      pix_next = '0;
    end else begin
      pix_next = place_gun(red_v,   gun_shifts[23:16], bpp) |
                 place_gun(green_v, gun_shifts[15:8],  bpp) |
                 place_gun(blue_v,  gun_shifts[7:0],   bpp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
    if (rdy4) pix4 <= pix_next;
  end

  // stage 5: byte order
  logic [31:0] bytes_next;
  logic [2:0]  count_next;

  always_comb begin
    if (bpp == 8'd8) begin
      count_next = 3'd1;
      bytes_next = {24'd0, pix4[7:0]};
    end else if (bpp == 8'd16) begin
      count_next = 3'd2;
      bytes_next = msb_first ? {16'd0, pix4[7:0], pix4[15:8]} : {16'd0, pix4[15:0]};
    end else begin
      count_next = 3'd4;
      bytes_next = msb_first ? {pix4[7:0], pix4[15:8], pix4[23:16], pix4[31:24]}
                             : pix4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rdy5) begin
      m_tvalid <= v4;
    end
    if (rdy5) begin
      m_tdata <= {5'd0, count_next, bytes_next};
    end
  end

  // checks
  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[34:32] == 3'd1 || m_tdata[34:32] == 3'd2 ||
                  m_tdata[34:32] == 3'd4))
    else $error("illegal byte count");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[34:32] != 3'd4 |-> m_tdata[31:16] == 16'd0)
    else $error("unused wire bytes not zero");

  a_write_no_word: assert property (@(posedge clk) disable iff (rst)
    in_accept && !is_convert |=> !v1)
    else $error("palette write entered the pipeline");

  a_write_lands: assert property (@(posedge clk) disable iff (rst)
    in_accept && !is_convert && in_hit |=>
      palette[$past(in_sel[ppfc_pkg::PAL_IDX_W-1:0])] ==
      $past({in_red, in_green, in_blue}))
    else $error("palette write lost");

endmodule

// ===== rtl/ppfc_gun_scale.sv =====
// ----------------------------------------------------------------------------
// ppfc_gun_scale
// Two-stage gun scaler: (g * max + 127) / 255, divide by reciprocal multiply.
// ----------------------------------------------------------------------------
module ppfc_gun_scale (
  input  logic                        clk,
  input  ppfc_pkg::stage_en_t         en,
  input  logic [ppfc_pkg::GUN_W-1:0]  gun,
  input  logic [ppfc_pkg::MAX_W-1:0]  gun_max,
  output logic [ppfc_pkg::MAX_W-1:0]  scaled
);

  logic [ppfc_pkg::PROD_W-1:0] prod;
  logic [ppfc_pkg::PROD_W+24:0] quot_full;

  assign quot_full = (ppfc_pkg::PROD_W + 25)'(prod) *
                     (ppfc_pkg::PROD_W + 25)'(ppfc_pkg::GUN_RECIP);

  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod <= ppfc_pkg::PROD_W'(gun) * ppfc_pkg::PROD_W'(gun_max) + ppfc_pkg::ROUND_BIAS;
    end
    if (en.div) begin
      scaled <= quot_full[ppfc_pkg::RECIP_K +: ppfc_pkg::MAX_W];
    end
  end

endmodule

// ===== sim/ppfc_pixel_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppfc_pixel_checker
// Watches the input, config and output channels of the palette pixel format
// converter. It keeps its own palette and format registers and works out the
// wire word for every accepted convert. Each output word is compared field by
// field with the oldest expected word.
// ----------------------------------------------------------------------------
module ppfc_pixel_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          fails,
  output int          pending,
  output int          checked
);

  localparam logic [31:0] HALF_STEP = 32'd127;
  localparam logic [31:0] FULL_SCALE = 32'd255;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  count;
  } wire_pix_t;

  wire_pix_t   wire_pix_q[$];
  logic [23:0] pal_lut[ppfc_pkg::PALETTE_ENTRIES];
  logic [7:0]  bpp_r;
  logic        big_end_r;
  logic        true_col_r;
  logic        two_col_r;
  logic [15:0] red_max_r;
  logic [15:0] grn_max_r;
  logic [15:0] blu_max_r;
  logic [23:0] shifts_r;

  initial begin
    fails = 0;
    pending = 0;
    checked = 0;
  end

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    fails++;
    if (fails <= MAX_PRINTS) begin
      $display("%0t: mismatch on %s, expected %h, got %h", $time, what, want, got);
    end
  endtask

  function automatic logic [31:0] gun_at(input logic [31:0] v, input logic [7:0] sh);
    if (sh >= bpp_r || sh >= 8'd32) begin
      return '0;
    end
    return v << sh;
  endfunction

  function automatic logic [31:0] gun_scaled(input logic [7:0] g, input logic [15:0] mx);
    return (32'(g) * 32'(mx) + HALF_STEP) / FULL_SCALE;
  endfunction

  function automatic wire_pix_t wire_pixel_of(input logic [3:0] idx);
    wire_pix_t   res;
    logic [23:0] ent;
    logic [31:0] pix;
    int          nb;
    int          src;
    ent = '0;
    if (int'(idx) < ppfc_pkg::PALETTE_ENTRIES) begin
      ent = pal_lut[idx];
    end
    if (!true_col_r) begin
      pix = {28'd0, idx};
    end else if (two_col_r) begin
      if (idx == 4'd0) begin
        pix = '0;
      end else begin
        pix = gun_at({16'd0, red_max_r}, shifts_r[23:16]) |
              gun_at({16'd0, grn_max_r}, shifts_r[15:8]) |
              gun_at({16'd0, blu_max_r}, shifts_r[7:0]);
      end
    end else begin
      pix = gun_at(gun_scaled(ent[23:16], red_max_r), shifts_r[23:16]) |
            gun_at(gun_scaled(ent[15:8], grn_max_r), shifts_r[15:8]) |
            gun_at(gun_scaled(ent[7:0], blu_max_r), shifts_r[7:0]);
    end
    if (bpp_r == 8'd8) begin
      nb = 1;
    end else if (bpp_r == 8'd16) begin
      nb = 2;
    end else begin
      nb = 4;
    end
    res.bytes = '0;
    res.count = 3'(nb);
    for (int k = 0; k < nb; k++) begin
      src = big_end_r ? (nb - 1 - k) : k;
      res.bytes[8*k +: 8] = pix[8*src +: 8];
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    wire_pix_t want;
    wire_pix_t got;
    if (rst) begin
      for (int i = 0; i < ppfc_pkg::PALETTE_ENTRIES; i++) begin
        pal_lut[i] = '0;
      end
      bpp_r = 8'd32;
      big_end_r = 1'b0;
      true_col_r = 1'b1;
      two_col_r = 1'b0;
      red_max_r = 16'd255;
      grn_max_r = 16'd255;
      blu_max_r = 16'd255;
      shifts_r = 24'h100800;
      wire_pix_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.bytes = m_tdata[31:0];
        got.count = m_tdata[34:32];
        if (wire_pix_q.size() == 0) begin
          report("unexpected word", '0, got.bytes);
        end else begin
          want = wire_pix_q.pop_front();
          checked++;
          if (got.bytes !== want.bytes) begin
            report("pixel_bytes", want.bytes, got.bytes);
          end
          if (got.count !== want.count) begin
            report("byte_count", 32'(want.count), 32'(got.count));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ppfc_pkg::CFG_BPP:        bpp_r = cfg_data[7:0];
          ppfc_pkg::CFG_BIG_ENDIAN: big_end_r = cfg_data[0];
          ppfc_pkg::CFG_TRUE_COL:   true_col_r = cfg_data[0];
          ppfc_pkg::CFG_TWO_COL:    two_col_r = cfg_data[0];
          ppfc_pkg::CFG_RED_MAX:    red_max_r = cfg_data[15:0];
          ppfc_pkg::CFG_GREEN_MAX:  grn_max_r = cfg_data[15:0];
          ppfc_pkg::CFG_BLUE_MAX:   blu_max_r = cfg_data[15:0];
          ppfc_pkg::CFG_SHIFTS:     shifts_r = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == ppfc_pkg::ACT_WRITE) begin
          if (int'(s_tdata[3:0]) < ppfc_pkg::PALETTE_ENTRIES) begin
            pal_lut[s_tdata[3:0]] = {s_tdata[11:4], s_tdata[19:12], s_tdata[27:20]};
          end
        end else begin
          wire_pix_q.push_back(wire_pixel_of(s_tdata[3:0]));
        end
      end
    end
    pending = wire_pix_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the palette pixel format converter. Palette loads and index
// converts are streamed under a series of pixel formats, with random idle
// cycles on both streams; the checker beside the block does the compare.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES = 14;
  localparam int WORDS_PER_PHASE = 125;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [23:0] cfg_data;

  int fails;
  int pending;
  int checked;
  int cycles = 0;
  int n_words = 0;
  int n_writes = 0;
  int n_formats = 0;
  int hold_left = 0;
  int sink_wait = 0;
  bit src_idle = 1'b0;
  bit sink_idle = 1'b0;

  palette_pixel_format_converter i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ppfc_pixel_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
      $display("[palette_pixel_format_converter] ERROR");
      $finish;
    end
  end

  // output side: long hold-off first, then per-word random stall
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (sink_wait > 0) begin
      m_tready <= 1'b0;
      sink_wait--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sink_wait = sink_idle ? $urandom_range(0, 19) : 0;
    end
  end

  task automatic send_word(input ppfc_pkg::action_e act, input logic [3:0] idx,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = src_idle ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {4'd0, b, g, r, idx};
    do @(posedge clk); while (!s_tready);
    n_words++;
    if (act == ppfc_pkg::ACT_WRITE) begin
      n_writes++;
    end
  endtask

  task automatic write_reg(input ppfc_pkg::cfg_reg_e idx, input logic [23:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for the output queue to empty, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_format(input logic [7:0] bpp, input logic be, input logic tc,
                            input logic two, input logic [15:0] rm, input logic [15:0] gm,
                            input logic [15:0] bm, input logic [23:0] sh);
    drain();
    write_reg(ppfc_pkg::CFG_BPP, {16'd0, bpp});
    write_reg(ppfc_pkg::CFG_BIG_ENDIAN, {23'd0, be});
    write_reg(ppfc_pkg::CFG_TRUE_COL, {23'd0, tc});
    write_reg(ppfc_pkg::CFG_TWO_COL, {23'd0, two});
    write_reg(ppfc_pkg::CFG_RED_MAX, {8'd0, rm});
    write_reg(ppfc_pkg::CFG_GREEN_MAX, {8'd0, gm});
    write_reg(ppfc_pkg::CFG_BLUE_MAX, {8'd0, bm});
    write_reg(ppfc_pkg::CFG_SHIFTS, sh);
    n_formats++;
  endtask

  function automatic logic [15:0] rand_max();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'((32'd1 << $urandom_range(1, 16)) - 1);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] rand_shift();
    if ($urandom_range(0, 3) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return 8'($urandom_range(0, 31));
  endfunction

  function automatic logic [7:0] rand_gun();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_words(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        src_idle = $urandom_range(0, 2) != 0;
        sink_idle = $urandom_range(0, 2) != 0;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_word(ppfc_pkg::ACT_WRITE, 4'($urandom_range(0, 15)),
                  rand_gun(), rand_gun(), rand_gun());
      end else begin
        send_word(ppfc_pkg::ACT_CONVERT, 4'($urandom_range(0, 15)), 8'd0, 8'd0, 8'd0);
      end
    end
  endtask

  initial begin
    logic [7:0] bpp;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset format: 32 bpp, little-endian, 8-bit guns at 16/8/0
    send_word(ppfc_pkg::ACT_WRITE, 4'd0, 8'h00, 8'h00, 8'h00);
    send_word(ppfc_pkg::ACT_WRITE, 4'd15, 8'hff, 8'hff, 8'hff);
    send_word(ppfc_pkg::ACT_WRITE, 4'd5, 8'h80, 8'h01, 8'h7f);
    send_word(ppfc_pkg::ACT_WRITE, 4'd10, 8'h55, 8'haa, 8'hfe);
    send_word(ppfc_pkg::ACT_CONVERT, 4'd0, 8'h00, 8'h00, 8'h00);
    send_word(ppfc_pkg::ACT_CONVERT, 4'd15, 8'h00, 8'h00, 8'h00);
    send_word(ppfc_pkg::ACT_CONVERT, 4'd5, 8'h00, 8'h00, 8'h00);
    send_word(ppfc_pkg::ACT_CONVERT, 4'd10, 8'h00, 8'h00, 8'h00);
    send_word(ppfc_pkg::ACT_CONVERT, 4'd3, 8'h00, 8'h00, 8'h00);
    // 16 bpp big-endian 565, high bytes dropped
    set_format(8'd16, 1'b1, 1'b1, 1'b0, 16'd31, 16'd63, 16'd31, {8'd11, 8'd5, 8'd0});
    send_word(ppfc_pkg::ACT_CONVERT, 4'd15, 8'h00, 8'h00, 8'h00);
    send_word(ppfc_pkg::ACT_CONVERT, 4'd5, 8'h00, 8'h00, 8'h00);
    // indexed
    set_format(8'd8, 1'b0, 1'b0, 1'b0, 16'd7, 16'd7, 16'd3, {8'd0, 8'd3, 8'd6});
    send_word(ppfc_pkg::ACT_CONVERT, 4'd0, 8'h00, 8'h00, 8'h00);
    send_word(ppfc_pkg::ACT_CONVERT, 4'd15, 8'h00, 8'h00, 8'h00);
    // black and white
    set_format(8'd32, 1'b1, 1'b1, 1'b1, 16'hffff, 16'd0, 16'hffff, {8'd16, 8'd8, 8'd0});
    send_word(ppfc_pkg::ACT_CONVERT, 4'd0, 8'h00, 8'h00, 8'h00);
    send_word(ppfc_pkg::ACT_CONVERT, 4'd7, 8'h00, 8'h00, 8'h00);
    // odd size, red spills past bit 31, green shifted off the word
    set_format(8'd24, 1'b0, 1'b1, 1'b0, 16'hffff, 16'hffff, 16'hffff,
               {8'd20, 8'd32, 8'd0});
    send_word(ppfc_pkg::ACT_CONVERT, 4'd15, 8'h00, 8'h00, 8'h00);
    send_word(ppfc_pkg::ACT_CONVERT, 4'd10, 8'h00, 8'h00, 8'h00);
    // zero-size pixel: every gun shifted off
    set_format(8'd0, 1'b1, 1'b1, 1'b0, 16'hffff, 16'hffff, 16'hffff, 24'd0);
    send_word(ppfc_pkg::ACT_CONVERT, 4'd15, 8'h00, 8'h00, 8'h00);
    set_format(8'd255, 1'b1, 1'b1, 1'b0, 16'hffff, 16'd255, 16'd1, {8'd31, 8'd31, 8'd255});
    send_word(ppfc_pkg::ACT_CONVERT, 4'd15, 8'h00, 8'h00, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: bpp = 8'd8;
        1: bpp = 8'd16;
        2: bpp = 8'd32;
        default: bpp = 8'($urandom_range(0, 255));
      endcase
      set_format(bpp, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 4) != 0),
                 1'($urandom_range(0, 3) == 0), rand_max(), rand_max(), rand_max(),
                 {rand_shift(), rand_shift(), rand_shift()});
      if (p == 3) begin
        // stall the output long enough to back up the input
        @(posedge clk);
        hold_left = 400;
        src_idle = 1'b0;
        for (int i = 0; i < 60; i++) begin
          send_word(ppfc_pkg::ACT_CONVERT, 4'($urandom_range(0, 15)), 8'd0, 8'd0, 8'd0);
        end
        drain();
        random_words(WORDS_PER_PHASE - 60);
      end else begin
        random_words(WORDS_PER_PHASE);
      end
    end

    drain();
    repeat (20) @(negedge clk);
    $display("sent %0d words (%0d palette loads) over %0d pixel formats",
             n_words, n_writes, n_formats);
    $display("compared %0d output words, %0d mismatches", checked, fails);
    if (fails == 0 && pending == 0) begin
      $display("[palette_pixel_format_converter] OK");
    end else begin
      $display("[palette_pixel_format_converter] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ppfc_pkg.sv
rtl/ppfc_gun_scale.sv
rtl/palette_pixel_format_converter.sv
sim/ppfc_pixel_checker.sv
sim/tb_top.sv
